@@ rtl/core/bl2x_pkg.sv @@
// Shared types, register indexes and helpers for the bilinear 2x upscaler.
package bl2x_pkg;

	localparam int PIX_W  = 8;
	localparam int ADDR_W = 24;
	localparam int SW_W   = 12;
	localparam int SH_W   = 12;
	localparam int STR_W  = 13;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEST_STRIDE = 2'd2;

	localparam logic [SW_W-1:0]  SRC_WIDTH_RST   = 12'd2048;
	localparam logic [SH_W-1:0]  SRC_HEIGHT_RST  = 12'd2048;
	localparam logic [STR_W-1:0] DEST_STRIDE_RST = 13'd4096;

	// Block codes, in emission order.
	localparam int BLK_N = 4;
	localparam logic [1:0] BLK_INNER  = 2'd0;
	localparam logic [1:0] BLK_RIGHT  = 2'd1;
	localparam logic [1:0] BLK_BOTTOM = 2'd2;
	localparam logic [1:0] BLK_CORNER = 2'd3;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// One source pixel in flight, with its position terms.
	typedef struct packed {
		logic  r_ge1;
		logic  c_ge1;
		logic  r_last;
		logic  c_last;
		addr_t row_base;
		addr_t col_off;
		addr_t stride2;
		pix_t  cur;
		pix_t  lf;
	} item_t;

	typedef struct packed {
		pix_t ul;
		pix_t up;
	} nbr_t;

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [PIX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[PIX_W:1];
	endfunction

endpackage

@@ rtl/core/bl2x_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
module bl2x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bl2x_front.sv @@
// Input side: configuration, position counters, line store and the held pixel stage.
module bl2x_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bl2x_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bl2x_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bl2x_pkg::PIX_W-1:0]    pixel,
	input  logic                          adv_s1,
	output logic                          valid_s1,
	output bl2x_pkg::item_t               item_s1,
	output bl2x_pkg::nbr_t                nbr_s1
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = CW + 1;
	localparam int HW = RW + 1;
	localparam int PW = RW + bl2x_pkg::STR_W;

	logic [bl2x_pkg::SW_W-1:0]  src_width_q;
	logic [bl2x_pkg::SH_W-1:0]  src_height_q;
	logic [bl2x_pkg::STR_W-1:0] dest_stride_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	bl2x_pkg::pix_t left_q;
	bl2x_pkg::pix_t ul_q;
	bl2x_pkg::pix_t up;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [CW-1:0] c_eff;
	logic [RW-1:0] r_eff;
	logic          c_last;
	logic          r_last;
	logic [PW-1:0] prod;
	logic          accept;
	bl2x_pkg::item_t item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= bl2x_pkg::SRC_WIDTH_RST;
			src_height_q  <= bl2x_pkg::SRC_HEIGHT_RST;
			dest_stride_q <= bl2x_pkg::DEST_STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bl2x_pkg::REG_SRC_WIDTH: begin
					src_width_q <= cfg_data[bl2x_pkg::SW_W-1:0];
				end
				bl2x_pkg::REG_SRC_HEIGHT: begin
					src_height_q <= cfg_data[bl2x_pkg::SH_W-1:0];
				end
				bl2x_pkg::REG_DEST_STRIDE: begin
					dest_stride_q <= cfg_data[bl2x_pkg::STR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Saturate the plane size to 2..MAX.
	always_comb begin
		if (src_width_q < 12'd2) begin
			w_eff = WW'(2);
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(src_width_q);
		end
		if (src_height_q < 12'd2) begin
			h_eff = HW'(2);
		end else if (32'(src_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(src_height_q);
		end
	end

	// A counter past a shrunken size restarts at zero.
	assign c_eff  = (WW'(col_q) >= w_eff) ? '0 : col_q;
	assign r_eff  = (HW'(row_q) >= h_eff) ? '0 : row_q;
	assign c_last = (WW'(c_eff) + WW'(1)) == w_eff;
	assign r_last = (HW'(r_eff) + HW'(1)) == h_eff;

	assign prod = PW'(r_eff) * PW'(dest_stride_q);

	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		item_d.r_ge1    = (r_eff != '0);
		item_d.c_ge1    = (c_eff != '0);
		item_d.r_last   = r_last;
		item_d.c_last   = c_last;
		item_d.row_base = {23'(prod), 1'b0};
		item_d.col_off  = bl2x_pkg::ADDR_W'({c_eff, 1'b0});
		item_d.stride2  = bl2x_pkg::ADDR_W'({dest_stride_q, 1'b0});
		item_d.cur      = pixel;
		item_d.lf       = left_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			ul_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (adv_s1) begin
				ul_q <= up;
			end
			if (accept) begin
				left_q <= pixel;
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : r_eff + RW'(1);
				end else begin
					col_q <= c_eff + CW'(1);
					row_q <= r_eff;
				end
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	// Read the pixel above and overwrite it with the current one.
	bl2x_ram #(
		.WIDTH (bl2x_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (c_eff),
		.wdata (pixel),
		.re    (accept),
		.raddr (c_eff),
		.rdata (up)
	);

	assign nbr_s1.ul = ul_q;
	assign nbr_s1.up = up;

endmodule

@@ rtl/core/bl2x_emit.sv @@
// Output side: builds the 2x2 blocks of the held pixel and drives the result register.
module bl2x_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic                          load_s1,
	input  bl2x_pkg::item_t               item_s1,
	input  bl2x_pkg::nbr_t                nbr_s1,
	output logic                          adv_s1,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bl2x_pkg::ADDR_W-1:0]   dest_addr,
	output logic [bl2x_pkg::PIX_W-1:0]    top_left,
	output logic [bl2x_pkg::PIX_W-1:0]    top_right,
	output logic [bl2x_pkg::PIX_W-1:0]    bottom_left,
	output logic [bl2x_pkg::PIX_W-1:0]    bottom_right,
	output logic                          last_of_run,
	output logic                          frame_done
);

	logic [bl2x_pkg::BLK_N-1:0] need;
	logic [bl2x_pkg::BLK_N-1:0] taken_q;
	logic [bl2x_pkg::BLK_N-1:0] pend;
	logic [bl2x_pkg::BLK_N-1:0] sel_oh;
	logic [bl2x_pkg::BLK_N-1:0] remain;
	logic [1:0]                 sel;
	logic                       out_free;
	logic                       out_load;

	bl2x_pkg::addr_t base_up;
	bl2x_pkg::addr_t col_left;
	bl2x_pkg::addr_t addr_d;
	bl2x_pkg::pix_t  tl_d;
	bl2x_pkg::pix_t  tr_d;
	bl2x_pkg::pix_t  bl_d;
	bl2x_pkg::pix_t  br_d;
	logic            done_d;

	logic            out_valid_q;
	bl2x_pkg::addr_t addr_q;
	bl2x_pkg::pix_t  tl_q;
	bl2x_pkg::pix_t  tr_q;
	bl2x_pkg::pix_t  bl_q;
	bl2x_pkg::pix_t  br_q;
	logic            last_q;
	logic            done_q;

	assign need[bl2x_pkg::BLK_INNER]  = item_s1.r_ge1 && item_s1.c_ge1;
	assign need[bl2x_pkg::BLK_RIGHT]  = item_s1.r_ge1 && item_s1.c_last;
	assign need[bl2x_pkg::BLK_BOTTOM] = item_s1.r_last && item_s1.c_ge1;
	assign need[bl2x_pkg::BLK_CORNER] = item_s1.r_last && item_s1.c_last;

	assign pend = valid_s1 ? (need & ~taken_q) : '0;

	// Pick the lowest pending block.
	always_comb begin
		if (pend[bl2x_pkg::BLK_INNER]) begin
			sel = bl2x_pkg::BLK_INNER;
		end else if (pend[bl2x_pkg::BLK_RIGHT]) begin
			sel = bl2x_pkg::BLK_RIGHT;
		end else if (pend[bl2x_pkg::BLK_BOTTOM]) begin
			sel = bl2x_pkg::BLK_BOTTOM;
		end else begin
			sel = bl2x_pkg::BLK_CORNER;
		end
	end

	assign sel_oh   = bl2x_pkg::BLK_N'(1) << sel;
	assign remain   = pend & ~sel_oh;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (pend != '0) && out_free;
	assign adv_s1   = valid_s1 && ((pend == '0) || (out_free && (remain == '0)));

	assign base_up  = item_s1.row_base - item_s1.stride2;
	assign col_left = item_s1.col_off - bl2x_pkg::ADDR_W'(2);

	always_comb begin
		done_d = 1'b0;
		case (sel)
			bl2x_pkg::BLK_INNER: begin
				addr_d = base_up + col_left;
				tl_d   = nbr_s1.ul;
				tr_d   = bl2x_pkg::avg2(nbr_s1.ul, nbr_s1.up);
				bl_d   = bl2x_pkg::avg2(nbr_s1.ul, item_s1.lf);
				br_d   = bl2x_pkg::avg2(nbr_s1.ul, item_s1.cur);
			end
			bl2x_pkg::BLK_RIGHT: begin
				addr_d = base_up + item_s1.col_off;
				tl_d   = nbr_s1.up;
				tr_d   = nbr_s1.up;
				bl_d   = bl2x_pkg::avg2(nbr_s1.up, item_s1.cur);
				br_d   = bl_d;
			end
			bl2x_pkg::BLK_BOTTOM: begin
				addr_d = item_s1.row_base + col_left;
				tl_d   = item_s1.lf;
				tr_d   = bl2x_pkg::avg2(item_s1.lf, item_s1.cur);
				bl_d   = item_s1.lf;
				br_d   = tr_d;
			end
			default: begin
				addr_d = item_s1.row_base + item_s1.col_off;
				tl_d   = item_s1.cur;
				tr_d   = item_s1.cur;
				bl_d   = item_s1.cur;
				br_d   = item_s1.cur;
				done_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new pixel starts with nothing sent.
			if (load_s1) begin
				taken_q <= '0;
			end else if (out_load) begin
				taken_q <= taken_q | sel_oh;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			addr_q <= addr_d;
			tl_q   <= tl_d;
			tr_q   <= tr_d;
			bl_q   <= bl_d;
			br_q   <= br_d;
			last_q <= (remain == '0);
			done_q <= done_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_addr    = addr_q;
	assign top_left     = tl_q;
	assign top_right    = tr_q;
	assign bottom_left  = bl_q;
	assign bottom_right = br_q;
	assign last_of_run  = last_q;
	assign frame_done   = done_q;

endmodule

@@ rtl/core/bilinear_2x_upscaler.sv @@
// Bilinear 2x upscaler top level: line store front end and block emitter.
// A pixel is registered into the held pixel stage, and each of its blocks then into the result register.
// Throughput: one pixel per cycle while each pixel makes at most one block and the output is free.
// The emitter sends one block per cycle while the output is free; input stalls until a pixel's last
// block is sent: at each row end after the first row, at later pixels of the last row and at the final one.
// Reset: counters, neighbor pixels and valids clear, registers take their defaults;
// line store is not cleared.
module bilinear_2x_upscaler #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bl2x_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bl2x_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bl2x_pkg::PIX_W-1:0]    pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bl2x_pkg::ADDR_W-1:0]   dest_addr,
	output logic [bl2x_pkg::PIX_W-1:0]    top_left,
	output logic [bl2x_pkg::PIX_W-1:0]    top_right,
	output logic [bl2x_pkg::PIX_W-1:0]    bottom_left,
	output logic [bl2x_pkg::PIX_W-1:0]    bottom_right,
	output logic                          last_of_run,
	output logic                          frame_done
);

	logic            valid_s1;
	logic            adv_s1;
	logic            load_s1;
	bl2x_pkg::item_t item_s1;
	bl2x_pkg::nbr_t  nbr_s1;

	assign load_s1 = in_valid && !in_stall;

	bl2x_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.adv_s1    (adv_s1),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.nbr_s1    (nbr_s1)
	);

	bl2x_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.load_s1      (load_s1),
		.item_s1      (item_s1),
		.nbr_s1       (nbr_s1),
		.adv_s1       (adv_s1),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dest_addr    (dest_addr),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done)
	);

endmodule
